FILE: hw/rtl/pmwb_pkg.sv
// ----------------------------------------------------------------------------
// pmwb_pkg: shared types and constants of the priority bitmap mutex
// Request modes, result status codes, register indexes and the bit search
// used over the 16-bit group and waiter maps.
// ----------------------------------------------------------------------------
package pmwb_pkg;

	localparam int PRIO_GROUPS = 16;
	localparam int MAP_W       = 16;
	localparam int IDX_W       = 4;
	localparam int PRIO_W      = 8;
	localparam int CODE_W      = 2;

	typedef enum logic [1:0] {
		MODE_LOCK    = 2'd0,
		MODE_TRY     = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_QUEUED = 2'd1,
		STAT_BUSY   = 2'd2
	} status_t;

	typedef enum logic {
		CFG_RECURSIVE  = 1'b0,
		CFG_START_FREE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// index of the lowest set bit, zero for an empty map
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [MAP_W-1:0] m);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/priority_mutex_waiter_bitmap.sv
// ----------------------------------------------------------------------------
// priority_mutex_waiter_bitmap: hardware mutex with a priority waiter bitmap
// Lock, try-lock and release requests against one mutex; waiters are kept in
// a two-level bitmap whose per-group maps sit in a small synchronous memory.
// ----------------------------------------------------------------------------
// Each request item passes through idle and execute: in the accept cycle the
// waiter map of the relevant group (the caller's group for a lock, the lowest
// occupied group for a release) is read from the map memory into a register,
// and in the execute state the word is updated, written back and the result
// item loaded into the output register. A new item is taken only once the
// block is back in idle, so it cannot take one before the last is through; a
// result waiting on m_tready holds the block in execute. A register write is
// taken only in idle, and an input item offered in the same cycle is held
// back while the write is offered. The map memory needs no clearing pass: a
// valid bit per group, cleared by reset and by a start_free write, makes an
// unwritten group read as empty.
module priority_mutex_waiter_bitmap
	import pmwb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] thread_prio, [9:8] release_code, [15:10] zero
	input  logic [1:0]  s_tuser,    // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [1:0] status, [9:2] granted_prio, [11:10] grant_code,
	                                // [12] preempt, [15:13] zero
	output logic        m_tuser,    // [0] grant_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	fsm_t state_q, state_nxt;

	logic              recursive_q;
	logic              start_free_q;
	logic              free_q;
	logic              owner_valid_q;
	logic [PRIO_W-1:0] owner_prio_q;
	logic [MAP_W-1:0]  group_map_q;
	logic [MAP_W-1:0]  wvalid_q;

	logic [MAP_W-1:0]  wmap_mem [MAP_W];
	logic [MAP_W-1:0]  rd_word_s1;
	logic              rd_valid_s1;

	logic [1:0]        mode_s1;
	logic [PRIO_W-1:0] prio_s1;
	logic [CODE_W-1:0] code_s1;
	logic [IDX_W-1:0]  grp_s1;

	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	logic              m_tuser_q;

	logic              in_acc;
	logic              cfg_acc;
	logic              exec_go;
	logic [IDX_W-1:0]  rd_addr;

	// result of the execute cycle
	logic              wr_en;
	logic [MAP_W-1:0]  wr_word;
	logic              nx_free;
	logic              nx_owner_valid;
	logic [PRIO_W-1:0] nx_owner_prio;
	logic [MAP_W-1:0]  nx_group_map;
	status_t           r_status;
	logic              r_gvalid;
	logic [PRIO_W-1:0] r_gprio;
	logic [CODE_W-1:0] r_gcode;
	logic              r_preempt;

	logic [MAP_W-1:0]  cur_word;
	logic [IDX_W-1:0]  bit_sel;
	logic [MAP_W-1:0]  rel_word;
	logic [PRIO_W-1:0] grant_prio;

	assign cfg_ready = (state_q == FSM_IDLE);
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_acc    = s_tvalid & s_tready;
	assign exec_go   = (state_q == FSM_EXEC) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// lock reads the caller's group, release the most urgent occupied group
	always_comb begin
		if (mode_t'(s_tuser) == MODE_RELEASE) begin
			rd_addr = lowest_bit(group_map_q);
		end else begin
			rd_addr = s_tdata[PRIO_W-1 -: IDX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				// hold input items while a register write is offered
				s_tready = !cfg_valid;
				if (s_tvalid && !cfg_valid) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (exec_go) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// map memory: read on accept, write back in the execute cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_word_s1 <= wmap_mem[rd_addr];
			mode_s1    <= s_tuser;
			prio_s1    <= s_tdata[PRIO_W-1:0];
			code_s1    <= s_tdata[PRIO_W +: CODE_W];
			grp_s1     <= rd_addr;
		end
		if (exec_go && wr_en) begin
			wmap_mem[grp_s1] <= wr_word;
		end
	end

	always_comb begin
		cur_word       = rd_valid_s1 ? rd_word_s1 : '0;
		bit_sel        = lowest_bit(cur_word);
		rel_word       = cur_word & ~(MAP_W'(1) << bit_sel);
		grant_prio     = {grp_s1, bit_sel};
		wr_en          = 1'b0;
		wr_word        = cur_word;
		nx_free        = free_q;
		nx_owner_valid = owner_valid_q;
		nx_owner_prio  = owner_prio_q;
		nx_group_map   = group_map_q;
		r_status       = STAT_DONE;
		r_gvalid       = 1'b0;
		r_gprio        = '0;
		r_gcode        = '0;
		r_preempt      = 1'b0;
		case (mode_t'(mode_s1))
			MODE_LOCK, MODE_TRY: begin
				if (recursive_q && owner_valid_q && (owner_prio_q == prio_s1)) begin
					r_status = STAT_DONE;
				end else if (free_q) begin
					nx_free        = 1'b0;
					nx_owner_valid = 1'b1;
					nx_owner_prio  = prio_s1;
				end else if (mode_t'(mode_s1) == MODE_TRY) begin
					r_status = STAT_BUSY;
				end else if (32'(grp_s1) < PRIO_GROUPS) begin
					wr_en                = 1'b1;
					wr_word              = cur_word | (MAP_W'(1) << prio_s1[IDX_W-1:0]);
					nx_group_map[grp_s1] = 1'b1;
					r_status             = STAT_QUEUED;
				end else begin
					r_status = STAT_BUSY;
				end
			end
			MODE_RELEASE: begin
				nx_owner_valid = 1'b0;
				nx_owner_prio  = '0;
				if (group_map_q == '0) begin
					nx_free = 1'b1;
				end else begin
					wr_en          = 1'b1;
					wr_word        = rel_word;
					if (rel_word == '0) begin
						nx_group_map[grp_s1] = 1'b0;
					end
					nx_owner_valid = 1'b1;
					nx_owner_prio  = grant_prio;
					r_gvalid       = 1'b1;
					r_gprio        = grant_prio;
					r_gcode        = code_s1;
					r_preempt      = grant_prio < prio_s1;
				end
			end
			default: begin
				// unused mode: no state change, all-zero result
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recursive_q   <= 1'b0;
			start_free_q  <= 1'b1;
			free_q        <= 1'b1;
			owner_valid_q <= 1'b0;
			owner_prio_q  <= '0;
			group_map_q   <= '0;
			wvalid_q      <= '0;
			rd_valid_s1   <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				rd_valid_s1 <= wvalid_q[rd_addr];
			end
			if (exec_go) begin
				free_q        <= nx_free;
				owner_valid_q <= nx_owner_valid;
				owner_prio_q  <= nx_owner_prio;
				group_map_q   <= nx_group_map;
				if (wr_en) begin
					wvalid_q[grp_s1] <= 1'b1;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_acc) begin
				case (cfg_idx_t'(cfg_index))
					CFG_RECURSIVE: begin
						recursive_q <= cfg_data;
					end
					CFG_START_FREE: begin
						// reinitialise the mutex: drop owner and all waiters
						start_free_q  <= cfg_data;
						free_q        <= cfg_data;
						owner_valid_q <= 1'b0;
						owner_prio_q  <= '0;
						group_map_q   <= '0;
						wvalid_q      <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			m_tdata_q <= {3'b000, r_preempt, r_gcode, r_gprio, r_status};
			m_tuser_q <= r_gvalid;
		end
	end

`ifndef SYNTHESIS
	a_free_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!(free_q && owner_valid_q))
		else $error("mutex free while owned");

	a_group_written: assert property (@(posedge clk) disable iff (!arst_n)
		(group_map_q & ~wvalid_q) == '0)
		else $error("group marked occupied without a written waiter map");

	a_grant_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[1:0] == STAT_DONE))
		else $error("grant result with non-done status");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == FSM_EXEC))
		else $error("accepted item not executed");

	a_start_free_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_acc && cfg_index == CFG_START_FREE) |=> (free_q == start_free_q))
		else $error("start_free write did not set availability");
`endif

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the priority bitmap mutex
// Drives lock, try-lock, release and unused-mode requests on the input stream
// and checks every result item against a behavioural mutex with its own
// two-level waiter bitmap. Directed cases come first, then random phases
// under varying input idling and output back-pressure, with register
// writes between phases and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
	import pmwb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		status_t     status;
		logic        grant_valid;
		logic [7:0]  granted_prio;
		logic [1:0]  grant_code;
		logic        preempt;
	} mutex_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;

	priority_mutex_waiter_bitmap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioural mutex state
	logic        recursive_on;
	logic        free_at_init;
	logic        mutex_free;
	logic        owned;
	logic [7:0]  owner;
	logic [15:0] group_bits;
	logic [15:0] waiter_bits [16];

	mutex_result_t pending_results [$];
	int mismatches = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT) begin
			$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	function automatic int first_set(input logic [15:0] m);
		int pos;
		pos = 0;
		for (int i = 0; i < 16; i++) begin
			if (m[i]) begin
				pos = i;
				break;
			end
		end
		return pos;
	endfunction

	task automatic clear_mutex();
		mutex_free = free_at_init;
		owned = 1'b0;
		owner = '0;
		group_bits = '0;
		for (int i = 0; i < 16; i++) begin
			waiter_bits[i] = '0;
		end
	endtask

	// advance the mutex by one request and return the result it yields
	function automatic mutex_result_t serve_request(input logic [1:0] md,
			input logic [7:0] pr, input logic [1:0] cd);
		mutex_result_t res;
		int grp;
		int bitpos;
		res = '0;
		res.status = STAT_DONE;
		if (md == MODE_LOCK || md == MODE_TRY) begin
			if (recursive_on && owned && owner == pr) begin
				res.status = STAT_DONE;
			end else if (mutex_free) begin
				mutex_free = 1'b0;
				owned = 1'b1;
				owner = pr;
			end else if (md == MODE_TRY) begin
				res.status = STAT_BUSY;
			end else begin
				grp = int'(pr[7:4]);
				if (grp < PRIO_GROUPS) begin
					group_bits[grp] = 1'b1;
					waiter_bits[grp][pr[3:0]] = 1'b1;
					res.status = STAT_QUEUED;
				end else begin
					res.status = STAT_BUSY;
				end
			end
		end else if (md == MODE_RELEASE) begin
			owned = 1'b0;
			owner = '0;
			if (group_bits == '0) begin
				mutex_free = 1'b1;
			end else begin
				grp = first_set(group_bits);
				bitpos = first_set(waiter_bits[grp]);
				waiter_bits[grp][bitpos] = 1'b0;
				if (waiter_bits[grp] == '0) begin
					group_bits[grp] = 1'b0;
				end
				owned = 1'b1;
				owner = {grp[3:0], bitpos[3:0]};
				res.grant_valid = 1'b1;
				res.granted_prio = owner;
				res.grant_code = cd;
				res.preempt = (owner < pr);
			end
		end
		return res;
	endfunction

	// check first, so a stray result cannot match an item taken at this edge
	always @(posedge clk or negedge arst_n) begin
		mutex_result_t want;
		if (!arst_n) begin
			recursive_on = 1'b0;
			free_at_init = 1'b1;
			clear_mutex();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", int'(m_tdata), 0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
					if (m_tuser !== want.grant_valid)
						report_mismatch("grant_valid", int'(m_tuser),
							int'(want.grant_valid));
					if (m_tdata[9:2] !== want.granted_prio)
						report_mismatch("granted_prio", int'(m_tdata[9:2]),
							int'(want.granted_prio));
					if (m_tdata[11:10] !== want.grant_code)
						report_mismatch("grant_code", int'(m_tdata[11:10]),
							int'(want.grant_code));
					if (m_tdata[12] !== want.preempt)
						report_mismatch("preempt", int'(m_tdata[12]), int'(want.preempt));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RECURSIVE) begin
					recursive_on = cfg_data;
				end else begin
					free_at_init = cfg_data;
					clear_mutex();
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(serve_request(s_tuser, s_tdata[7:0], s_tdata[9:8]));
			end
		end
	end

	// output side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_asked != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("priority_mutex_waiter_bitmap verification failed");
			$finish;
		end
	end

	// leaves s_tvalid high; the caller drops it before waiting on anything else
	task automatic send_item(input logic [1:0] md, input logic [7:0] pr,
			input logic [1:0] cd);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= md;
		s_tdata <= {6'd0, cd, pr};
		do @(posedge clk); while (!s_tready);
	endtask

	// one edge first, so the item taken at the last edge is already queued
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_basic_requests();
		send_item(MODE_LOCK, 8'h00, 2'd3);
		send_item(MODE_TRY, 8'hFF, 2'd0);
		send_item(MODE_LOCK, 8'hFF, 2'd1);
		send_item(MODE_LOCK, 8'hFF, 2'd2);
		send_item(MODE_LOCK, 8'h10, 2'd0);
		// owner asks again without recursion: it joins the waiters
		send_item(MODE_LOCK, 8'h00, 2'd0);
		send_item(MODE_RELEASE, 8'h00, 2'd3);
		send_item(MODE_RELEASE, 8'h80, 2'd1);
		// released by a thread that does not own the mutex
		send_item(MODE_RELEASE, 8'h05, 2'd2);
		send_item(MODE_RELEASE, 8'hFF, 2'd3);
		send_item(MODE_UNUSED, 8'hFF, 2'd3);
		send_item(MODE_TRY, 8'hAA, 2'd0);
		send_item(MODE_UNUSED, 8'h00, 2'd0);
		wait_idle();
	endtask

	task automatic test_recursive_owner();
		cfg_write(CFG_RECURSIVE, 1'b1);
		send_item(MODE_RELEASE, 8'hAA, 2'd0);
		send_item(MODE_LOCK, 8'h42, 2'd0);
		send_item(MODE_LOCK, 8'h42, 2'd1);
		send_item(MODE_TRY, 8'h42, 2'd2);
		send_item(MODE_LOCK, 8'h43, 2'd0);
		send_item(MODE_RELEASE, 8'h42, 2'd2);
		wait_idle();
	endtask

	task automatic test_start_taken();
		cfg_write(CFG_START_FREE, 1'b0);
		send_item(MODE_LOCK, 8'h20, 2'd0);
		send_item(MODE_TRY, 8'h01, 2'd0);
		send_item(MODE_RELEASE, 8'h30, 2'd1);
		send_item(MODE_RELEASE, 8'h20, 2'd0);
		send_item(MODE_TRY, 8'h01, 2'd0);
		wait_idle();
		cfg_write(CFG_START_FREE, 1'b1);
		cfg_write(CFG_RECURSIVE, 1'b0);
	endtask

	task automatic test_random_traffic(input int count, input int idle, input int stall);
		logic [7:0] pool [6];
		logic [1:0] md;
		logic [7:0] pr;
		int pick;
		for (int i = 0; i < 6; i++) begin
			pool[i] = 8'($urandom_range(255));
		end
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				md = MODE_LOCK;
			else if (pick < 60)
				md = MODE_TRY;
			else if (pick < 95)
				md = MODE_RELEASE;
			else
				md = MODE_UNUSED;
			// reuse a few threads so owners relock and waiters queue twice
			if ($urandom_range(1))
				pr = pool[$urandom_range(5)];
			else
				pr = 8'($urandom_range(255));
			send_item(md, pr, 2'($urandom_range(3)));
		end
		wait_idle();
	endtask

	task automatic test_output_hold();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		holds_asked++;
		for (int n = 0; n < 40; n++) begin
			send_item(2'($urandom_range(2)), 8'($urandom_range(255)),
				2'($urandom_range(3)));
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_recursive_owner();
		test_start_taken();
		test_random_traffic(350, 0, 0);
		cfg_write(CFG_RECURSIVE, 1'b1);
		test_random_traffic(350, 49, 0);
		cfg_write(CFG_START_FREE, 1'b0);
		cfg_write(CFG_RECURSIVE, 1'b0);
		test_random_traffic(350, 0, 49);
		cfg_write(CFG_START_FREE, 1'b1);
		cfg_write(CFG_RECURSIVE, 1'($urandom_range(1)));
		test_random_traffic(350, 17, 17);
		test_output_hold();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("priority_mutex_waiter_bitmap verification clean");
		end else begin
			$display("priority_mutex_waiter_bitmap verification failed");
		end
		$finish;
	end

endmodule

FILE: priority_mutex_waiter_bitmap.f
hw/rtl/pmwb_pkg.sv
hw/rtl/priority_mutex_waiter_bitmap.sv
sim/tb_top.sv
